// ===== hw/rtl/pdcp_pkg.sv =====
package pdcp_pkg;

    localparam int LINE_CELLS       = 260;
    localparam int PREAMBLE_LINES   = 4;
    localparam int FIRST_PIXEL_CELL = 26;

    localparam int LANES       = 8;
    localparam int KEY_W       = 8;
    localparam int CODE_W      = 2;
    localparam int LUT_REGS    = 8;
    localparam int LUT_REG_W   = 64;
    localparam int LUT_SEL_W   = 3;
    localparam int CFG_IDX_W   = 4;
    localparam int COLUMN_W    = 11;
    localparam int GROUP_W     = 8;
    localparam int WORD_W      = 32;
    localparam int HALF_W      = 16;
    localparam int INDEX_W     = 19;
    localparam int PATTERN_W   = LANES * CODE_W;

    typedef enum logic {
        CMD_ENCODE = 1'b0,
        CMD_CLEAR  = 1'b1
    } t_cmd;

    typedef logic [KEY_W-1:0] t_key;

    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] index;
        logic [LUT_REG_W-1:0] data;
    } t_cfg_wr;

endpackage

// ===== hw/rtl/pdcp_lut.sv =====
module pdcp_lut (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pdcp_pkg::t_cfg_wr             i_cfg,
    input  pdcp_pkg::t_key                i_keys [pdcp_pkg::LANES],
    output logic [pdcp_pkg::PATTERN_W-1:0] o_pattern
);
    import pdcp_pkg::*;

    logic [LUT_REG_W-1:0] r_lut [LUT_REGS];

    // writes with an index past the last table register are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LUT_REGS; i++) begin
                r_lut[i] <= '0;
            end
        end else if (i_cfg.we && (i_cfg.index < CFG_IDX_W'(LUT_REGS))) begin
            r_lut[i_cfg.index[LUT_SEL_W-1:0]] <= i_cfg.data;
        end
    end

    // key[7:5] picks the register, key[4:0] the 2-bit code within it; lane 0 lands on top
    always_comb begin
        o_pattern = '0;
        for (int l = 0; l < LANES; l++) begin
            o_pattern[(LANES-1-l)*CODE_W +: CODE_W] =
                r_lut[i_keys[l][KEY_W-1 -: LUT_SEL_W]]
                     [{i_keys[l][KEY_W-LUT_SEL_W-1:0], 1'b0} +: CODE_W];
        end
    end

endmodule

// ===== hw/rtl/panel_drive_cell_packer_unit.sv =====
// Panel drive cell packer.
// Input channel (i_in_valid / o_in_ready) carries one beat per group of eight
// pixels of a column: command, column, row group, the current scanout word and
// eight transition keys. Output channel (o_out_valid / i_out_ready) returns the
// word index in the slot and the new word (upper half kept, low half the packed
// drive codes or zero on clear).
// The drive code table is loaded through i_cfg_we / i_cfg_index / i_cfg_data,
// one 64-bit register per write; the user must load it only while no beat is
// in flight, which the block itself does not enforce. Beats pass the input
// register, then the result register after the table lookup and index multiply.
// Throughput: one beat per cycle via the two-stage pipeline unless stalled.
// A stalled receiver holds the result register; the input register keeps
// taking one more beat, then o_in_ready drops until the output moves.
// Reset clears both valid flags and all table registers to zero.
module panel_drive_cell_packer_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_cmd,
    input  logic [pdcp_pkg::COLUMN_W-1:0]     i_column,
    input  logic [pdcp_pkg::GROUP_W-1:0]      i_row_group,
    input  logic [pdcp_pkg::WORD_W-1:0]       i_existing_word,
    input  logic [pdcp_pkg::KEY_W-1:0]        i_key_0,
    input  logic [pdcp_pkg::KEY_W-1:0]        i_key_1,
    input  logic [pdcp_pkg::KEY_W-1:0]        i_key_2,
    input  logic [pdcp_pkg::KEY_W-1:0]        i_key_3,
    input  logic [pdcp_pkg::KEY_W-1:0]        i_key_4,
    input  logic [pdcp_pkg::KEY_W-1:0]        i_key_5,
    input  logic [pdcp_pkg::KEY_W-1:0]        i_key_6,
    input  logic [pdcp_pkg::KEY_W-1:0]        i_key_7,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [pdcp_pkg::INDEX_W-1:0]      o_word_index,
    output logic [pdcp_pkg::WORD_W-1:0]       o_new_word,
    input  logic                              i_cfg_we,
    input  logic [pdcp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pdcp_pkg::LUT_REG_W-1:0]    i_cfg_data
);
    import pdcp_pkg::*;

    localparam int PROD_W = 22;

    logic                r_s1_valid;
    t_cmd                r_s1_cmd;
    logic [COLUMN_W-1:0] r_s1_column;
    logic [GROUP_W-1:0]  r_s1_group;
    logic [WORD_W-1:0]   r_s1_word;
    t_key                r_s1_keys [LANES];

    logic                r_s2_valid;
    logic [INDEX_W-1:0]  r_word_index;
    logic [WORD_W-1:0]   r_new_word;

    logic                s1_advance;
    logic                in_accept;
    t_cfg_wr             cfg;
    logic [PATTERN_W-1:0] pattern;
    logic [PROD_W-1:0]   n_index;
    logic [WORD_W-1:0]   n_new_word;

    assign s1_advance = r_s1_valid && (!r_s2_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_advance;
    assign in_accept  = i_in_valid && o_in_ready;

    assign cfg.we    = i_cfg_we;
    assign cfg.index = i_cfg_index;
    assign cfg.data  = i_cfg_data;

    pdcp_lut u_lut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_keys    (r_s1_keys),
        .o_pattern (pattern)
    );

    always_comb begin
        n_index = (PROD_W'(r_s1_column) + PROD_W'(PREAMBLE_LINES)) * PROD_W'(LINE_CELLS)
                  + PROD_W'(FIRST_PIXEL_CELL) + PROD_W'(r_s1_group);
        unique case (r_s1_cmd)
            CMD_ENCODE: n_new_word = {r_s1_word[WORD_W-1:HALF_W], pattern};
            CMD_CLEAR:  n_new_word = {r_s1_word[WORD_W-1:HALF_W], {HALF_W{1'b0}}};
            default:    n_new_word = {r_s1_word[WORD_W-1:HALF_W], {HALF_W{1'b0}}};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_advance) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_advance) begin
                r_s2_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_s2_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_cmd     <= t_cmd'(i_cmd);
            r_s1_column  <= i_column;
            r_s1_group   <= i_row_group;
            r_s1_word    <= i_existing_word;
            r_s1_keys[0] <= i_key_0;
            r_s1_keys[1] <= i_key_1;
            r_s1_keys[2] <= i_key_2;
            r_s1_keys[3] <= i_key_3;
            r_s1_keys[4] <= i_key_4;
            r_s1_keys[5] <= i_key_5;
            r_s1_keys[6] <= i_key_6;
            r_s1_keys[7] <= i_key_7;
        end
        if (s1_advance) begin
            r_word_index <= n_index[INDEX_W-1:0];
            r_new_word   <= n_new_word;
        end
    end

    assign o_out_valid  = r_s2_valid;
    assign o_word_index = r_word_index;
    assign o_new_word   = r_new_word;

endmodule

// ===== bench/panel_drive_cell_packer_unit_tb.sv =====
module panel_drive_cell_packer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pdcp_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 4;
    localparam int LONG_HOLD    = 300;
    localparam int RESET_CYCLES = 12;

    typedef struct packed {
        t_cmd                             cmd;
        logic [COLUMN_W-1:0]              column;
        logic [GROUP_W-1:0]               row_group;
        logic [WORD_W-1:0]                existing_word;
        logic [LANES-1:0][KEY_W-1:0]      keys;
    } t_cell_beat;

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic [WORD_W-1:0]  word;
    } t_cell_result;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  out_ready = 1'b0;
    t_cell_beat            beat_q    = '0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [LUT_REG_W-1:0]  cfg_data  = '0;

    logic                  o_in_ready;
    logic                  o_out_valid;
    logic [INDEX_W-1:0]    o_word_index;
    logic [WORD_W-1:0]     o_new_word;

    logic [LUT_REG_W-1:0]  drive_lut [LUT_REGS];
    t_cell_beat            beats_to_send [$];
    t_cell_result          cells_due [$];

    int  errors    = 0;
    int  cycles    = 0;
    int  gap_left  = 0;
    int  stall_left = 0;
    int  hold_left = 0;
    bit  hold_req  = 1'b0;
    bit  hold_done = 1'b0;
    bit  no_idle   = 1'b0;

    panel_drive_cell_packer_unit uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (o_in_ready),
        .i_cmd           (beat_q.cmd),
        .i_column        (beat_q.column),
        .i_row_group     (beat_q.row_group),
        .i_existing_word (beat_q.existing_word),
        .i_key_0         (beat_q.keys[0]),
        .i_key_1         (beat_q.keys[1]),
        .i_key_2         (beat_q.keys[2]),
        .i_key_3         (beat_q.keys[3]),
        .i_key_4         (beat_q.keys[4]),
        .i_key_5         (beat_q.keys[5]),
        .i_key_6         (beat_q.keys[6]),
        .i_key_7         (beat_q.keys[7]),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (out_ready),
        .o_word_index    (o_word_index),
        .o_new_word      (o_new_word),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // lane 0 lands in the top two bits of the pattern half
    function automatic t_cell_result pack_cell(input t_cell_beat b);
        t_cell_result         r;
        logic [PATTERN_W-1:0] pattern;
        logic [KEY_W-1:0]     k;
        logic [31:0]          flat_index;
        pattern = '0;
        if (b.cmd == CMD_ENCODE) begin
            for (int lane = 0; lane < LANES; lane++) begin
                k = b.keys[lane];
                pattern[(LANES-1-lane)*CODE_W +: CODE_W] =
                    drive_lut[k[7:5]][k[4:0]*CODE_W +: CODE_W];
            end
        end
        flat_index = (PREAMBLE_LINES + b.column) * LINE_CELLS + FIRST_PIXEL_CELL
                     + b.row_group;
        r.index = flat_index[INDEX_W-1:0];
        r.word  = {b.existing_word[WORD_W-1:HALF_W], pattern};
        return r;
    endfunction

    function automatic t_cell_beat random_beat();
        t_cell_beat b;
        b.cmd = ($urandom_range(0, 3) == 0) ? CMD_CLEAR : CMD_ENCODE;
        // mostly on-panel positions, now and then the full field range
        b.column = ($urandom_range(0, 15) == 0) ? COLUMN_W'($urandom_range(0, 2047))
                                                 : COLUMN_W'($urandom_range(0, 1403));
        b.row_group = ($urandom_range(0, 15) == 0) ? GROUP_W'($urandom_range(0, 255))
                                                    : GROUP_W'($urandom_range(0, 233));
        b.existing_word = $urandom;
        for (int lane = 0; lane < LANES; lane++)
            b.keys[lane] = KEY_W'($urandom_range(0, 255));
        return b;
    endfunction

    task automatic queue_beat(input t_cmd cmd, input int col, input int grp,
                              input logic [WORD_W-1:0] word,
                              input logic [LANES*KEY_W-1:0] keys);
        t_cell_beat b;
        b.cmd           = cmd;
        b.column        = COLUMN_W'(col);
        b.row_group     = GROUP_W'(grp);
        b.existing_word = word;
        b.keys          = keys;
        beats_to_send.push_back(b);
    endtask

    task automatic write_lut(input int idx, input logic [LUT_REG_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_IDX_W'(idx);
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx < LUT_REGS)
            drive_lut[LUT_SEL_W'(idx)] = val;
    endtask

    task automatic settle();
        while (beats_to_send.size() != 0 || in_valid || cells_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic random_phase(input int count, input bit pressure);
        for (int n = 0; n < count; n++)
            beats_to_send.push_back(random_beat());
        if (pressure)
            hold_req = 1'b1;
        settle();
    endtask

    always @(posedge clk) begin : beat_driver
        logic slot_free;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready)
                cells_due.push_back(pack_cell(beat_q));
            slot_free = !in_valid || o_in_ready;
            if (slot_free) begin
                if (gap_left == 0 && !no_idle && beats_to_send.size() != 0
                    && $urandom_range(0, 7) == 0)
                    gap_left = $urandom_range(1, 18);
                if (gap_left != 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (beats_to_send.size() != 0) begin
                    beat_q   <= beats_to_send.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin : ready_gen
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            // long hold-off: the pipe fills and the input side backs up
            hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 18) - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin : result_check
        t_cell_result want;
        if (rst_n && o_out_valid && out_ready) begin
            if (cells_due.size() == 0) begin
                $display("%0t: unexpected beat, index %0d word %h", $time,
                         o_word_index, o_new_word);
                errors++;
            end else begin
                want = cells_due.pop_front();
                if (o_word_index !== want.index) begin
                    $display("%0t: word_index expected %0d actual %0d", $time,
                             want.index, o_word_index);
                    errors++;
                end
                if (o_new_word !== want.word) begin
                    $display("%0t: new_word expected %h actual %h", $time,
                             want.word, o_new_word);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk) begin : watchdog
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("panel_drive_cell_packer_unit_tb: done, errors");
            $finish;
        end
    end

    initial begin
        for (int r = 0; r < LUT_REGS; r++)
            drive_lut[r] = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // table still at reset: every encode gives an all-zero pattern
        queue_beat(CMD_ENCODE, 0, 0, 32'hFFFF_FFFF, {LANES{8'hFF}});
        queue_beat(CMD_ENCODE, 1403, 233, $urandom, {$urandom, $urandom});
        settle();

        // codes 0,1,2,3 repeating so every key position is visible
        for (int r = 0; r < LUT_REGS; r++)
            write_lut(r, {8{8'hE4}} ^ {32{r[1:0]}});
        queue_beat(CMD_ENCODE, 0, 0, 32'h0000_0000, 64'h0706_0504_0302_0100);
        queue_beat(CMD_ENCODE, 1403, 233, 32'hFFFF_FFFF, 64'hFFDF_BF9F_7F5F_3F1F);
        queue_beat(CMD_ENCODE, 2047, 255, $urandom, 64'hE0C0_A080_6040_2000);
        queue_beat(CMD_CLEAR, 2047, 255, 32'hFFFF_FFFF, {LANES{8'hFF}});
        queue_beat(CMD_CLEAR, 0, 0, 32'h0000_0000, {LANES{8'h00}});
        queue_beat(CMD_CLEAR, 700, 117, $urandom, {$urandom, $urandom});
        queue_beat(CMD_ENCODE, 1403, 0, 32'hAAAA_5555, {LANES{8'hFF}});
        queue_beat(CMD_ENCODE, 0, 233, 32'h5555_AAAA, {LANES{8'h00}});
        queue_beat(CMD_ENCODE, 2047, 0, 32'h0000_FFFF, 64'h0001_0203_0405_0607);
        queue_beat(CMD_ENCODE, 1900, 200, 32'hFFFF_0000, {$urandom, $urandom});
        queue_beat(CMD_ENCODE, 1404, 234, $urandom, 64'h8040_2010_0804_0201);
        queue_beat(CMD_ENCODE, 1, 1, $urandom, 64'hFEFD_FBF7_EFDF_BF7F);
        settle();

        // indexes past the table are dropped by the block
        for (int r = LUT_REGS; r < (1 << CFG_IDX_W); r++)
            write_lut(r, {$urandom, $urandom});
        queue_beat(CMD_ENCODE, 5, 9, $urandom, 64'hE0C0_A080_6040_2000);
        queue_beat(CMD_ENCODE, 6, 10, $urandom, 64'hFFDF_BF9F_7F5F_3F1F);
        settle();

        for (int r = 0; r < LUT_REGS; r++)
            write_lut(r, {$urandom, $urandom});
        random_phase(70, 1'b0);

        for (int r = 0; r < LUT_REGS; r++)
            write_lut(r, {LUT_REG_W{1'b1}});
        random_phase(70, 1'b1);

        for (int r = 0; r < LUT_REGS; r++)
            write_lut(r, r[0] ? {16{4'hA}} : {16{4'h5}});
        random_phase(65, 1'b0);

        for (int r = 0; r < (1 << CFG_IDX_W); r++)
            write_lut(r, {$urandom, $urandom});
        random_phase(65, 1'b0);

        for (int r = 0; r < LUT_REGS; r++)
            write_lut(r, '0);
        random_phase(40, 1'b0);

        for (int r = 0; r < LUT_REGS; r++)
            write_lut(r, {$urandom, $urandom});
        no_idle = 1'b1;
        random_phase(90, 1'b0);

        if (errors == 0)
            $display("panel_drive_cell_packer_unit_tb: done, clean");
        else
            $display("panel_drive_cell_packer_unit_tb: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/pdcp_pkg.sv
hw/rtl/pdcp_lut.sv
hw/rtl/panel_drive_cell_packer_unit.sv
bench/panel_drive_cell_packer_unit_tb.sv
